/* src/gpc_pkg.sv */
// ---------------------------------------------------------------------------
// gpc_pkg: shared constants and types of the grid path cost block
// Sizes of the grid, widths of costs and path sums, and the control group
// that steers the line buffer chain.
// ---------------------------------------------------------------------------
`default_nettype none

package gpc_pkg;

	// Largest grid side and number of cost bits that take part in the sum.
	localparam int MAX_GRID  = 1024;
	localparam int COST_BITS = 16;

	// Field widths fixed by the interface.
	localparam int COST_W = 16;
	localparam int PATH_W = 27;
	localparam int CFG_W  = 11;

	// Grid index and grid size widths.
	localparam int IDX_W  = $clog2(MAX_GRID);
	localparam int SIZE_W = $clog2(MAX_GRID) + 1;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BEST_MODE = 1'b1;

	// Best path selection.
	localparam logic MODE_MIN = 1'b0;
	localparam logic MODE_MAX = 1'b1;

	typedef logic [COST_W-1:0] cost_t;
	typedef logic [PATH_W-1:0] path_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [SIZE_W-1:0] size_t;

	// Control of the line buffer: advance by one item, and the cell that
	// takes the new value so that it leaves the far end one row later.
	typedef struct packed {
		logic shift;
		idx_t ins_pos;
	} line_ctl_t;

endpackage

`default_nettype wire

/* src/gpc_if.sv */
// ---------------------------------------------------------------------------
// gpc_if: valid/ready channels of the grid path cost block
// One channel carries cell costs in, the other carries path costs out.
// ---------------------------------------------------------------------------
`default_nettype none

interface gpc_in_if import gpc_pkg::*; ();
	logic  valid;
	logic  ready;
	cost_t cell_cost;

	modport source (output valid, output cell_cost, input ready);
	modport sink (input valid, input cell_cost, output ready);
endinterface

interface gpc_out_if import gpc_pkg::*; ();
	logic  valid;
	logic  ready;
	path_t path_cost;
	logic  grid_done;

	modport source (output valid, output path_cost, output grid_done, input ready);
	modport sink (input valid, input path_cost, input grid_done, output ready);
endinterface

`default_nettype wire

/* src/gpc_cell.sv */
// ---------------------------------------------------------------------------
// gpc_cell: one stage of the line buffer chain
// Holds one path cost and on each shift takes either its neighbour's value
// or the freshly computed one.
// ---------------------------------------------------------------------------
`default_nettype none

module gpc_cell import gpc_pkg::*; (
	input  wire   clk,
	input  wire   shift,
	input  wire   load,
	input  path_t d_new,
	input  path_t d_prev,
	output path_t q
);

	path_t val_q;

	// Payload only, so no reset.
	always_ff @(posedge clk) begin
		if (shift) begin
			val_q <= load ? d_new : d_prev;
		end
	end

	assign q = val_q;

endmodule

`default_nettype wire

/* src/gpc_line.sv */
// ---------------------------------------------------------------------------
// gpc_line: line buffer built as a chain of cells
// A value enters at a cell chosen by the grid size and reaches the far end
// after exactly one row of items, where it is read as the cell below.
// ---------------------------------------------------------------------------
`default_nettype none

module gpc_line import gpc_pkg::*; (
	input  wire       clk,
	input  line_ctl_t ctl,
	input  path_t     d_new,
	output path_t     tail
);

	path_t cell_q [MAX_GRID];

	// The chain: each cell passes its value to the next one on every shift.
	for (genvar k = 0; k < MAX_GRID; k++) begin : g_cell
		path_t prev;

		if (k == 0) begin : g_head
			assign prev = d_new;
		end else begin : g_body
			assign prev = cell_q[k-1];
		end

		gpc_cell u_cell (
			.clk    (clk),
			.shift  (ctl.shift),
			.load   (ctl.ins_pos == IDX_W'(k)),
			.d_new  (d_new),
			.d_prev (prev),
			.q      (cell_q[k])
		);
	end

	assign tail = cell_q[MAX_GRID-1];

endmodule

`default_nettype wire

/* src/grid_path_cost_dp_core.sv */
// ---------------------------------------------------------------------------
// grid_path_cost_dp_core: best down-right path cost over a streamed grid
// Cells arrive in reverse raster order; each result is the minimum or
// maximum cost of a down/right path from that cell to the bottom-right corner.
// ---------------------------------------------------------------------------
// Use of the block:
//   cell_in carries one cell cost per item, last row first and within a row
//   last column first. path_out returns one item per input item, in order,
//   with grid_done set on the top-left cell that closes a grid.
//   The configuration port writes grid_size (index 0, restarts the grid) and
//   best_mode (index 1, 0 for minimum, 1 for maximum) while the block is idle.
//   A result is in the output register on the edge after its item is
//   accepted. Without a stall, throughput is one item per cycle, set by the
//   single add, compare and saturate path in front of the output register.
//   The row below is held in a chain of MAX_GRID cells; a new value enters
//   at the cell that makes it reach the far end one row of items later.
//   Reset sets a grid of MAX_GRID, minimum mode and empties the output
//   register; the chain needs no clearing since a row is always written
//   before it is read. When the receiver stalls the output register holds
//   its item and cell_in stays ready only while that register can drain.
// ---------------------------------------------------------------------------
`default_nettype none

module grid_path_cost_dp_core import gpc_pkg::*; (
	input  wire                  clk,
	input  wire                  arst_n,
	gpc_in_if.sink               cell_in,
	gpc_out_if.source            path_out,
	input  wire                  cfg_we,
	input  wire [CFG_IDX_W-1:0]  cfg_index,
	input  wire [CFG_W-1:0]      cfg_data
);

	// Grid position and configuration state.
	size_t n_q;
	idx_t  ins_pos_q;
	idx_t  row_q;
	idx_t  col_q;
	path_t right_q;
	logic  mode_q;

	// Output register.
	logic  out_valid_q;
	path_t path_q;
	logic  done_q;

	logic      accept;
	idx_t      last_idx;
	logic      have_below;
	logic      have_right;
	logic      at_origin;
	path_t     below;
	path_t     best;
	logic      [PATH_W:0] sum;
	path_t     v;
	size_t     new_size;
	line_ctl_t line_ctl;

	// Handshake: take an item whenever the output register is free or draining.
	assign cell_in.ready = !out_valid_q || path_out.ready;
	assign accept        = cell_in.valid && cell_in.ready;

	assign last_idx   = IDX_W'(n_q - SIZE_W'(1));
	assign have_below = (row_q != last_idx);
	assign have_right = (col_q != last_idx);
	assign at_origin  = (row_q == '0) && (col_q == '0);

	// Choose among the neighbours that lie inside the grid.
	always_comb begin
		priority if (have_below && have_right) begin
			if (mode_q == MODE_MAX) begin
				best = (below > right_q) ? below : right_q;
			end else begin
				best = (below < right_q) ? below : right_q;
			end
		end else if (have_below) begin
			best = below;
		end else if (have_right) begin
			best = right_q;
		end else begin
			best = '0;
		end
	end

	// Add this cell's cost and saturate at the top of the path range.
	assign sum = {1'b0, best} + (PATH_W+1)'(cell_in.cell_cost[COST_BITS-1:0]);
	assign v   = sum[PATH_W] ? '1 : sum[PATH_W-1:0];

	// Grid size as written, held within one and MAX_GRID.
	always_comb begin
		logic [31:0] wr;
		wr = 32'(cfg_data);
		if (wr == 32'd0) begin
			new_size = SIZE_W'(1);
		end else if (wr > 32'(MAX_GRID)) begin
			new_size = SIZE_W'(MAX_GRID);
		end else begin
			new_size = SIZE_W'(wr);
		end
	end

	// Line buffer of the row below.
	assign line_ctl.shift   = accept;
	assign line_ctl.ins_pos = ins_pos_q;

	gpc_line u_line (
		.clk   (clk),
		.ctl   (line_ctl),
		.d_new (v),
		.tail  (below)
	);

	// Position, right neighbour and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q       <= SIZE_W'(MAX_GRID);
			ins_pos_q <= '0;
			row_q     <= IDX_W'(MAX_GRID - 1);
			col_q     <= IDX_W'(MAX_GRID - 1);
			right_q   <= '0;
			mode_q    <= MODE_MIN;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GRID_SIZE: begin
					n_q       <= new_size;
					ins_pos_q <= IDX_W'(SIZE_W'(MAX_GRID) - new_size);
					row_q     <= IDX_W'(new_size - SIZE_W'(1));
					col_q     <= IDX_W'(new_size - SIZE_W'(1));
					right_q   <= '0;
				end
				REG_BEST_MODE: begin
					mode_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end else if (accept) begin
			if (col_q == '0) begin
				col_q   <= last_idx;
				row_q   <= (row_q == '0) ? last_idx : row_q - IDX_W'(1);
				right_q <= '0;
			end else begin
				col_q   <= col_q - IDX_W'(1);
				right_q <= v;
			end
		end
	end

	// Output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (path_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			path_q <= v;
			done_q <= at_origin;
		end
	end

	assign path_out.valid     = out_valid_q;
	assign path_out.path_cost = path_q;
	assign path_out.grid_done = done_q;

`ifndef ASSERT_OFF
	// An accepted item always shows up in the output register on the next edge.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> path_out.valid)
		else $error("accepted item produced no result");

	// Closing a grid sends both indices back to the bottom-right corner.
	a_grid_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && at_origin && !cfg_we) |=> (row_q == last_idx) && (col_q == last_idx))
		else $error("grid did not wrap to the corner");

	// Neither grid index ever leaves the grid in use.
	a_col_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		(SIZE_W'(col_q) < n_q) && (SIZE_W'(row_q) < n_q))
		else $error("grid index outside the grid");

	// The corner cell's result is its own cost.
	a_corner_cost: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !have_below && !have_right) |=>
		(path_out.path_cost == PATH_W'($past(cell_in.cell_cost[COST_BITS-1:0]))))
		else $error("corner result differs from its cost");

	// The input side only stalls behind a full and stalled output register.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!cell_in.ready |-> (path_out.valid && !path_out.ready))
		else $error("input stalled without an output stall");
`endif

endmodule

`default_nettype wire
